[hw/rtl/fbps_pkg.sv]
// Shared constants and types for the finite-buffer packet scheduler.
// No dependencies; imported by fbps_ram and finite_buffer_packet_scheduler.
package fbps_pkg;

  localparam int TIME_W        = 32;
  localparam int CAP_W         = 9;
  localparam int DEPTH_DEFAULT = 256;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_CHECK  = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_t;

endpackage

[hw/rtl/finite_buffer_packet_scheduler.sv]
// Single-server tail-drop scheduler: an input transfer runs through READ and CHECK for each
// finish time it retires from the queue head and once more, then through DECIDE, which waits
// while the result register is stalled and then registers the result; the next input transfer
// is taken after the return to IDLE. Retirement runs through the one read port of the
// finish-time RAM (read, then compare), one entry per pass. The input is stalled while an
// item is at work; the result register lets the next transfer start while a result waits.
// The RAM needs no clearing. Depends on fbps_pkg and fbps_ram.
module finite_buffer_packet_scheduler
  import fbps_pkg::*;
#(
  parameter int BUFFER_DEPTH = DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CAP_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TIME_W-1:0] in_arrival_time,
  input  logic [TIME_W-1:0] in_service_duration,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_dropped,
  output logic [TIME_W-1:0] out_start_time
);

  localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  state_t            state_r, state_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [TIME_W-1:0] arr_r, dur_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_dropped_r, out_dropped_nxt;
  logic [TIME_W-1:0] out_start_r, out_start_nxt;

  logic [TIME_W-1:0] rd_data;
  logic              in_xfer, out_free, retire, has_room, push;
  logic [TIME_W-1:0] lf_max;
  logic [CNT_W:0]    tail_sum;
  logic [PTR_W-1:0]  tail;
  logic [CMP_W-1:0]  cap_ext, cap_eff;

  fbps_ram #(
    .DEPTH  (BUFFER_DEPTH),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (tail),
    .wdata (last_nxt),
    .raddr (head_r),
    .rdata (rd_data)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign lf_max   = (arr_r > last_r) ? arr_r : last_r;
  assign tail_sum = (CNT_W+1)'(head_r) + (CNT_W+1)'(count_r);
  assign tail     = (tail_sum >= (CNT_W+1)'(BUFFER_DEPTH))
                    ? PTR_W'(tail_sum - (CNT_W+1)'(BUFFER_DEPTH)) : PTR_W'(tail_sum);
  assign cap_ext  = CMP_W'(cap_r);
  assign cap_eff  = (cap_ext > CMP_W'(BUFFER_DEPTH)) ? CMP_W'(BUFFER_DEPTH) : cap_ext;
  assign has_room = CMP_W'(count_r) < cap_eff;
  assign retire   = (state_r == ST_CHECK) && (count_r != '0) && (arr_r >= rd_data);
  assign push     = (state_r == ST_DECIDE) && out_free && has_room;

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    last_nxt        = last_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_dropped_nxt = out_dropped_r;
    out_start_nxt   = out_start_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (retire) begin
          head_nxt  = (head_r == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
          count_nxt = count_r - CNT_W'(1);
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (has_room) begin
            last_nxt        = lf_max + dur_r;
            count_nxt       = count_r + CNT_W'(1);
            out_dropped_nxt = 1'b0;
            out_start_nxt   = lf_max;
          end else begin
            last_nxt        = lf_max;
            out_dropped_nxt = 1'b1;
            out_start_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      head_r      <= '0;
      count_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_dropped_r <= out_dropped_nxt;
    out_start_r   <= out_start_nxt;
    if (in_xfer) begin
      arr_r <= in_arrival_time;
      dur_r <= in_service_duration;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dropped    = out_dropped_r;
  assign out_start_time = out_start_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(BUFFER_DEPTH))
    else $error("queue count above depth");

  a_out_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DECIDE))
    else $error("result raised outside decide step");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dropped_r |-> out_start_r == '0)
    else $error("dropped result with nonzero start time");

  a_xfer_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ST_READ)
    else $error("input transfer did not start head read");
`endif

endmodule

[hw/rtl/fbps_ram.sv]
// Simple dual-port RAM holding the finish-time queue: one write port and one
// read port with registered read data. Depends on fbps_pkg.
module fbps_ram
  import fbps_pkg::*;
#(
  parameter int DEPTH  = DEPTH_DEFAULT,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [TIME_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [TIME_W-1:0] rdata
);

  logic [TIME_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
